// File: design/qir_pkg.sv
// ----------------------------------------------------------------------------
// qir_pkg: shared types and constants for the queue imbalance rebalancer
// sizes, request codes, register map, worker table word and controller states
// ----------------------------------------------------------------------------
package qir_pkg;

    // sizes
    localparam int NUM_QUEUES  = 8;
    localparam int MAX_WORKERS = 16;
    localparam int COUNT_BITS  = 16;

    localparam int Q_IDX_W  = $clog2(NUM_QUEUES);
    localparam int W_IDX_W  = $clog2(MAX_WORKERS);
    localparam int SCAN_W   = (W_IDX_W > Q_IDX_W) ? W_IDX_W : Q_IDX_W;
    localparam int WCOUNT_W = 5;
    localparam int RATIO_W  = 23;
    localparam int TOTAL_W  = 32;
    localparam int DIV_CNT_W = $clog2(RATIO_W);

    // apb register file
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // arithmetic constants
    localparam int PCT_SCALE   = 100;
    localparam int EMPTY_RATIO = 1000;

    // request kinds
    localparam logic [1:0] KIND_QUEUE  = 2'd0;
    localparam logic [1:0] KIND_WORKER = 2'd1;
    localparam logic [1:0] KIND_CHECK  = 2'd2;

    // register indexes
    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_MIN_DEPTH = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_WCOUNT    = 2'd3;

    // one entry of the worker table
    typedef struct packed {
        logic               pending;
        logic [Q_IDX_W-1:0] queue;
        logic               free;
    } t_worker;

    localparam int WORKER_W = $bits(t_worker);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QSCAN,
        ST_QEND,
        ST_DECIDE,
        ST_DIV,
        ST_RCHK,
        ST_WSCAN,
        ST_WEND,
        ST_DONE
    } t_state;

endpackage

// File: design/qir_ram.sv
// ----------------------------------------------------------------------------
// qir_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module qir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/queue_imbalance_rebalancer.sv
// ----------------------------------------------------------------------------
// queue_imbalance_rebalancer: max/min queue load balancer
// tracks per-queue waiting counts and per-worker status in two rams and, on a
// balance check, moves a free worker from the emptiest to the fullest queue
// ----------------------------------------------------------------------------
// a queue or worker update writes its ram on accept and then loads the result register
// a balance check scans the queue ram and decides, then may run the bit-serial ratio
// divide (skipped when the emptiest queue is empty), the threshold check and the
// worker ram scan before it loads and presents the result
// one request at a time; the next is accepted once the controller is idle
// reset (synchronous, active low) clears counters, config, control state and
// the per-entry valid bits, so every ram entry reads as zero until written
module queue_imbalance_rebalancer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // apb configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qir_pkg::ADDR_W-1:0]           paddr,
    input  logic [qir_pkg::DATA_W-1:0]           pwdata,
    output logic [qir_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready,

    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_kind,
    input  logic [qir_pkg::Q_IDX_W-1:0]          i_queue_sel,
    input  logic [qir_pkg::COUNT_BITS-1:0]       i_queue_level,
    input  logic [qir_pkg::W_IDX_W-1:0]          i_worker_sel,
    input  logic                                 i_worker_is_free,
    input  logic [qir_pkg::Q_IDX_W-1:0]          i_worker_assign,

    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_moved,
    output logic [qir_pkg::W_IDX_W-1:0]          o_moved_worker,
    output logic [qir_pkg::Q_IDX_W-1:0]          o_source_queue,
    output logic [qir_pkg::Q_IDX_W-1:0]          o_target_queue,
    output logic [qir_pkg::RATIO_W-1:0]          o_load_ratio,
    output logic [qir_pkg::TOTAL_W-1:0]          o_check_total,
    output logic [qir_pkg::TOTAL_W-1:0]          o_rebalance_total
);

    import qir_pkg::*;

    // config registers
    logic                  r_enable;
    logic [COUNT_BITS-1:0] r_min_depth;
    logic [RATIO_W-1:0]    r_threshold;
    logic [WCOUNT_W-1:0]   r_wcount;

    // controller state
    t_state r_state, n_state;

    // running totals
    logic [TOTAL_W-1:0] r_checks, n_checks;
    logic [TOTAL_W-1:0] r_rebal,  n_rebal;

    // scan index and read tracking
    logic [SCAN_W-1:0] r_idx,  n_idx;
    logic [SCAN_W-1:0] r_pidx, n_pidx;
    logic              r_qpend, n_qpend;
    logic              r_wpend, n_wpend;

    // per-entry valid bits, and the valid bit of the entry just read
    logic [NUM_QUEUES-1:0]  r_qvalid;
    logic [MAX_WORKERS-1:0] r_wvalid;
    logic                   r_q_rvld;
    logic                   r_w_rvld;

    // max/min search
    logic [COUNT_BITS-1:0] r_max, n_max;
    logic [COUNT_BITS-1:0] r_min, n_min;
    logic [Q_IDX_W-1:0]    r_max_idx, n_max_idx;
    logic [Q_IDX_W-1:0]    r_min_idx, n_min_idx;
    logic                  r_have_max, n_have_max;

    // divider: r_num shifts the dividend out and the quotient in
    logic [RATIO_W-1:0]    r_num, n_num;
    logic [COUNT_BITS-1:0] r_rem, n_rem;
    logic [DIV_CNT_W-1:0]  r_dcnt, n_dcnt;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  qbit;

    // result being built
    logic                  r_moved, n_moved;
    logic [W_IDX_W-1:0]    r_mworker, n_mworker;
    logic [Q_IDX_W-1:0]    r_src, n_src;
    logic [Q_IDX_W-1:0]    r_tgt, n_tgt;
    logic [RATIO_W-1:0]    r_ratio, n_ratio;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic                  out_load;
    logic                  r_out_moved;
    logic [W_IDX_W-1:0]    r_out_mworker;
    logic [Q_IDX_W-1:0]    r_out_src;
    logic [Q_IDX_W-1:0]    r_out_tgt;
    logic [RATIO_W-1:0]    r_out_ratio;
    logic [TOTAL_W-1:0]    r_out_checks;
    logic [TOTAL_W-1:0]    r_out_rebal;

    // ram ports
    logic                  q_we, q_re;
    logic [Q_IDX_W-1:0]    q_waddr, q_raddr;
    logic [COUNT_BITS-1:0] q_wdata, q_rdata, q_data;
    logic                  w_we, w_re;
    logic [W_IDX_W-1:0]    w_waddr, w_raddr;
    t_worker               w_wdata, w_rdata, w_data;

    logic                  cfg_we;
    logic [WCOUNT_W-1:0]   limit;
    logic                  w_last;
    logic                  w_match;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_min_depth <= '0;
            r_threshold <= '0;
            r_wcount    <= '0;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_ENABLE:    r_enable    <= pwdata[0];
                REG_MIN_DEPTH: r_min_depth <= pwdata[COUNT_BITS-1:0];
                REG_THRESHOLD: r_threshold <= pwdata[RATIO_W-1:0];
                REG_WCOUNT:    r_wcount    <= pwdata[WCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ENABLE:    prdata = DATA_W'(r_enable);
            REG_MIN_DEPTH: prdata = DATA_W'(r_min_depth);
            REG_THRESHOLD: prdata = DATA_W'(r_threshold);
            REG_WCOUNT:    prdata = DATA_W'(r_wcount);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // state memories
    // ------------------------------------------------------------------
    qir_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_QUEUES)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    qir_ram #(
        .WIDTH (WORKER_W),
        .DEPTH (MAX_WORKERS)
    ) u_worker_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entries never written read as zero
    assign q_data = r_q_rvld ? q_rdata : '0;
    assign w_data = r_w_rvld ? w_rdata : '0;

    // idle search covers at most the whole table
    assign limit  = (r_wcount > WCOUNT_W'(MAX_WORKERS)) ? WCOUNT_W'(MAX_WORKERS) : r_wcount;
    assign w_last = (WCOUNT_W'(r_idx) + WCOUNT_W'(1)) == limit;

    // worker read back last cycle is free and serves the emptiest queue
    assign w_match = r_wpend && w_data.free && (w_data.queue == r_min_idx);

    // one restoring divide step
    assign rem_sh = {r_rem, r_num[RATIO_W-1]};
    assign qbit   = rem_sh >= {1'b0, r_min};

    assign o_in_stall = (r_state != ST_IDLE);

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_checks    = r_checks;
        n_rebal     = r_rebal;
        n_idx       = r_idx;
        n_pidx      = r_pidx;
        n_qpend     = 1'b0;
        n_wpend     = 1'b0;
        n_max       = r_max;
        n_min       = r_min;
        n_max_idx   = r_max_idx;
        n_min_idx   = r_min_idx;
        n_have_max  = r_have_max;
        n_num       = r_num;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_moved     = r_moved;
        n_mworker   = r_mworker;
        n_src       = r_src;
        n_tgt       = r_tgt;
        n_ratio     = r_ratio;
        out_load    = 1'b0;

        q_we    = 1'b0;
        q_waddr = i_queue_sel;
        q_wdata = i_queue_level;
        q_re    = 1'b0;
        q_raddr = r_idx[Q_IDX_W-1:0];

        w_we    = 1'b0;
        w_waddr = i_worker_sel;
        w_wdata = '{pending: 1'b0, queue: i_worker_assign, free: i_worker_is_free};
        w_re    = 1'b0;
        w_raddr = r_idx[W_IDX_W-1:0];

        // fold the queue count read last cycle into the max/min search
        if (r_qpend) begin
            if (r_pidx == '0) begin
                n_min     = q_data;
                n_min_idx = '0;
            end else if (q_data < r_min) begin
                n_min     = q_data;
                n_min_idx = r_pidx[Q_IDX_W-1:0];
            end
            if (q_data > r_max) begin
                n_max      = q_data;
                n_max_idx  = r_pidx[Q_IDX_W-1:0];
                n_have_max = 1'b1;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_moved   = 1'b0;
                    n_mworker = '0;
                    n_src     = '0;
                    n_tgt     = '0;
                    n_ratio   = '0;
                    n_state   = ST_DONE;
                    case (i_kind)
                        KIND_QUEUE: begin
                            q_we = 1'b1;
                        end
                        KIND_WORKER: begin
                            // a status update also clears the pending flag
                            w_we = 1'b1;
                        end
                        KIND_CHECK: begin
                            if (r_enable) begin
                                n_checks   = r_checks + TOTAL_W'(1);
                                n_max      = '0;
                                n_max_idx  = '0;
                                n_have_max = 1'b0;
                                n_idx      = '0;
                                n_state    = ST_QSCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_QSCAN: begin
                q_re    = 1'b1;
                n_qpend = 1'b1;
                n_pidx  = r_idx;
                if (r_idx == SCAN_W'(NUM_QUEUES - 1)) begin
                    n_state = ST_QEND;
                end else begin
                    n_idx = r_idx + SCAN_W'(1);
                end
            end

            ST_QEND: begin
                // last queue count folds in this cycle
                n_state = ST_DECIDE;
            end

            ST_DECIDE: begin
                if (!r_have_max || (r_max_idx == r_min_idx) || (r_max < r_min_depth)) begin
                    n_state = ST_DONE;
                end else if (r_min == '0) begin
                    n_ratio = RATIO_W'(EMPTY_RATIO);
                    n_state = ST_RCHK;
                end else begin
                    n_num   = RATIO_W'(RATIO_W'(r_max) * RATIO_W'(PCT_SCALE));
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_state = ST_DIV;
                end
            end

            ST_DIV: begin
                n_rem  = qbit ? COUNT_BITS'(rem_sh - {1'b0, r_min}) : rem_sh[COUNT_BITS-1:0];
                n_num  = {r_num[RATIO_W-2:0], qbit};
                n_dcnt = r_dcnt + DIV_CNT_W'(1);
                if (r_dcnt == DIV_CNT_W'(RATIO_W - 1)) begin
                    n_ratio = {r_num[RATIO_W-2:0], qbit};
                    n_state = ST_RCHK;
                end
            end

            ST_RCHK: begin
                if ((r_ratio < r_threshold) || (limit == '0)) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx   = '0;
                    n_state = ST_WSCAN;
                end
            end

            ST_WSCAN, ST_WEND: begin
                if (w_match) begin
                    // move the worker and flag the reassignment
                    w_we      = 1'b1;
                    w_waddr   = r_pidx[W_IDX_W-1:0];
                    w_wdata   = '{pending: 1'b1, queue: r_max_idx, free: 1'b1};
                    n_rebal   = r_rebal + TOTAL_W'(1);
                    n_moved   = 1'b1;
                    n_mworker = r_pidx[W_IDX_W-1:0];
                    n_src     = r_min_idx;
                    n_tgt     = r_max_idx;
                    n_state   = ST_DONE;
                end else if (r_state == ST_WEND) begin
                    n_state = ST_DONE;
                end else begin
                    w_re    = 1'b1;
                    n_wpend = 1'b1;
                    n_pidx  = r_idx;
                    if (w_last) begin
                        n_state = ST_WEND;
                    end else begin
                        n_idx = r_idx + SCAN_W'(1);
                    end
                end
            end

            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // ------------------------------------------------------------------
    // control registers with reset
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checks    <= '0;
            r_rebal     <= '0;
            r_qpend     <= 1'b0;
            r_wpend     <= 1'b0;
            r_qvalid    <= '0;
            r_wvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_checks    <= n_checks;
            r_rebal     <= n_rebal;
            r_qpend     <= n_qpend;
            r_wpend     <= n_wpend;
            r_out_valid <= n_out_valid;
            if (q_we) begin
                r_qvalid[q_waddr] <= 1'b1;
            end
            if (w_we) begin
                r_wvalid[w_waddr] <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_max      <= n_max;
        r_min      <= n_min;
        r_max_idx  <= n_max_idx;
        r_min_idx  <= n_min_idx;
        r_have_max <= n_have_max;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_dcnt     <= n_dcnt;
        r_moved    <= n_moved;
        r_mworker  <= n_mworker;
        r_src      <= n_src;
        r_tgt      <= n_tgt;
        r_ratio    <= n_ratio;
        if (q_re) begin
            r_q_rvld <= r_qvalid[q_raddr];
        end
        if (w_re) begin
            r_w_rvld <= r_wvalid[w_raddr];
        end
        if (out_load) begin
            r_out_moved   <= r_moved;
            r_out_mworker <= r_mworker;
            r_out_src     <= r_src;
            r_out_tgt     <= r_tgt;
            r_out_ratio   <= r_ratio;
            r_out_checks  <= r_checks;
            r_out_rebal   <= r_rebal;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_moved           = r_out_moved;
    assign o_moved_worker    = r_out_mworker;
    assign o_source_queue    = r_out_src;
    assign o_target_queue    = r_out_tgt;
    assign o_load_ratio      = r_out_ratio;
    assign o_check_total     = r_out_checks;
    assign o_rebalance_total = r_out_rebal;

endmodule
